// ===== rtl/core/sha1s_pkg.sv =====
package sha1s_pkg;

  // Message byte counter width (bit length = count * 8, modulo 2^64)
  localparam int unsigned CountW = 61;

  // One queued transaction from the front end
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } item_t;

  // Initial chaining value
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Round group boundaries and the last round
  localparam logic [6:0] Round20   = 7'd20;
  localparam logic [6:0] Round40   = 7'd40;
  localparam logic [6:0] Round60   = 7'd60;
  localparam logic [6:0] LastRound = 7'd79;

  // Block offsets: start of the length field, last byte of a block
  localparam logic [5:0] LenPos   = 6'(448 / 8);
  localparam logic [5:0] BlockEnd = 6'd63;

  // Padding marker byte
  localparam logic [7:0] PadMark = 8'h80;

  // Boolean function of a round
  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < Round20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < Round40) begin
      f = b ^ c ^ d;
    end else if (rnd < Round60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Additive constant of a round
  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < Round20) begin
      k = K0;
    end else if (rnd < Round40) begin
      k = K1;
    end else if (rnd < Round60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/sha1s_front.sv =====
module sha1s_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic [0:0]          in_tuser,   // [0] has_byte
  input  logic                in_tlast,
  output logic                q_valid,
  output sha1s_pkg::item_t    q_item,
  input  logic                q_ready
);

  // Two-entry queue between front end and hash engine
  sha1s_pkg::item_t mem [2];
  logic [1:0]       cnt_r;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic             keep;
  logic             push;
  logic             pop;

  // Drop transactions that carry neither a byte nor an end of message
  assign keep      = in_tuser[0] | in_tlast;
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= '{data: in_tdata, has: in_tuser[0], last: in_tlast};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/sha1s_engine.sv =====
module sha1s_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sha1s_pkg::item_t    q_item,
  output logic                q_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [159:0]        out_tdata
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_ADD, S_OUT} state_t;
  typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN} phase_t;

  state_t                       state_r;
  phase_t                       phase_r;
  logic                         pad_act_r;
  logic                         pad_done_r;
  logic [sha1s_pkg::CountW-1:0] count_r;
  logic [63:0]                  len_r;
  logic [31:0]                  word_r;
  logic [31:0]                  sched_r [16];
  logic [31:0]                  a_r, b_r, c_r, d_r, e_r;
  logic [6:0]                   rnd_r;
  logic [31:0]                  h_r [5];
  logic                         out_valid_r;
  logic [159:0]                 out_data_r;

  logic [5:0]                   pos;
  logic                         eff_len;
  logic [7:0]                   pad_byte;
  logic                         take;
  logic                         wr_en;
  logic [7:0]                   wr_byte;
  logic [31:0]                  word_nxt;
  logic [sha1s_pkg::CountW-1:0] count_inc;
  logic [sha1s_pkg::CountW-1:0] cnt_after;
  logic                         blk_full;
  logic [31:0]                  t_sum;
  logic [31:0]                  sched_new;
  logic [31:0]                  sched_x;
  logic                         slot_free;

  // Block offset of the next byte
  assign pos = count_r[5:0];

  // Padding byte: marker, zeros, then the bit length big-endian
  assign eff_len = (phase_r == P_LEN) || ((phase_r == P_ZERO) && (pos == sha1s_pkg::LenPos));
  always_comb begin
    priority if (phase_r == P_MARK) begin
      pad_byte = sha1s_pkg::PadMark;
    end else if (eff_len) begin
      pad_byte = len_r[{~pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Byte write path shared by message and padding bytes
  assign q_ready   = (state_r == S_IDLE);
  assign take      = q_valid && q_ready;
  assign wr_en     = (take && q_item.has) || (state_r == S_PAD);
  assign wr_byte   = (state_r == S_PAD) ? pad_byte : q_item.data;
  assign word_nxt  = {word_r[23:0], wr_byte};
  assign count_inc = count_r + {{(sha1s_pkg::CountW-1){1'b0}}, 1'b1};
  assign cnt_after = q_item.has ? count_inc : count_r;
  assign blk_full  = wr_en && (pos == sha1s_pkg::BlockEnd);

  // One round: schedule extension and the working-variable update
  assign sched_x   = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign t_sum     = {a_r[26:0], a_r[31:27]} + sha1s_pkg::round_f(rnd_r, b_r, c_r, d_r)
                   + e_r + sha1s_pkg::round_k(rnd_r) + sched_r[0];

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: bytes, padding, compression rounds, final add, digest output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_MARK;
      pad_act_r   <= 1'b0;
      pad_done_r  <= 1'b0;
      count_r     <= '0;
      rnd_r       <= 7'd0;
      h_r[0]      <= sha1s_pkg::Iv0;
      h_r[1]      <= sha1s_pkg::Iv1;
      h_r[2]      <= sha1s_pkg::Iv2;
      h_r[3]      <= sha1s_pkg::Iv3;
      h_r[4]      <= sha1s_pkg::Iv4;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      // Pack the byte; shift each completed word into the schedule window
      if (wr_en) begin
        word_r  <= word_nxt;
        count_r <= count_inc;
        if (pos[1:0] == 2'd3) begin
          for (int i = 0; i < 15; i++) begin
            sched_r[i] <= sched_r[i+1];
          end
          sched_r[15] <= word_nxt;
        end
      end

      // Start compression on a full block
      if (blk_full) begin
        a_r     <= h_r[0];
        b_r     <= h_r[1];
        c_r     <= h_r[2];
        d_r     <= h_r[3];
        e_r     <= h_r[4];
        rnd_r   <= 7'd0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (q_item.last) begin
              pad_act_r <= 1'b1;
              phase_r   <= P_MARK;
              len_r     <= {cnt_after, 3'b000};
            end
            if (blk_full) begin
              state_r <= S_COMP;
            end else if (q_item.last) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (phase_r == P_MARK) begin
            phase_r <= P_ZERO;
          end else if (eff_len) begin
            phase_r <= P_LEN;
          end
          if (eff_len && (pos == sha1s_pkg::BlockEnd)) begin
            pad_done_r <= 1'b1;
          end
          if (blk_full) begin
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          for (int i = 0; i < 15; i++) begin
            sched_r[i] <= sched_r[i+1];
          end
          sched_r[15] <= sched_new;
          a_r   <= t_sum;
          b_r   <= a_r;
          c_r   <= {b_r[1:0], b_r[31:2]};
          d_r   <= c_r;
          e_r   <= d_r;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == sha1s_pkg::LastRound) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          priority if (pad_done_r) begin
            state_r <= S_OUT;
          end else if (pad_act_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          // Hold until the output register is free, then restart the chain
          if (slot_free) begin
            out_data_r  <= {h_r[4], h_r[2], h_r[3], h_r[0], h_r[1]};
            out_valid_r <= 1'b1;
            h_r[0]      <= sha1s_pkg::Iv0;
            h_r[1]      <= sha1s_pkg::Iv1;
            h_r[2]      <= sha1s_pkg::Iv2;
            h_r[3]      <= sha1s_pkg::Iv3;
            h_r[4]      <= sha1s_pkg::Iv4;
            count_r     <= '0;
            pad_act_r   <= 1'b0;
            pad_done_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sha1_stream_hash.sv =====
// Channel | Ports              | Payload
// --------+--------------------+--------------------------------------------------
// input   | in_tvalid/in_tready| tdata[7:0] data_byte, tuser[0] has_byte, tlast
// result  | out_tvalid/tready  | tdata[63:0] high, [127:64] mid, [159:128] low
//
// A byte-carrying transaction is packed as the engine takes it; the 64th byte of a
// block starts 80 rounds (one round per cycle) and then the chaining add.
// End of message emits padding one byte per cycle through the same path, up to two
// blocks, pausing while a block is compressed; then the digest register is loaded.
// rst_n is synchronous, active low, and restores the initial chaining value.
// A two-entry queue decouples input acceptance from the engine; the engine stalls
// only when a new digest finds the previous one not yet taken.
module sha1_stream_hash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic [0:0]   in_tuser,    // [0] has_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata    // [63:0] digest_high, [127:64] digest_mid,
                                    // [159:128] digest_low
);

  logic             q_valid;
  logic             q_ready;
  sha1s_pkg::item_t q_item;

  // Accept and classify transactions
  sha1s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  // Pack, pad, compress and emit digests
  sha1s_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
